/* rtl/wss_pkg.sv */
// Shared types and constants of the wildcard signature scanner.
package wss_pkg;

    // Signature bytes held in configuration registers
    localparam int SIG_BYTES = 32;
    // Signature byte that matches any data byte
    localparam logic [7:0] WILDCARD = 8'h99;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_PAT_0_7   = 3'd0,
        CFG_PAT_8_15  = 3'd1,
        CFG_PAT_16_23 = 3'd2,
        CFG_PAT_24_31 = 3'd3,
        CFG_LENGTH    = 3'd4,
        CFG_STRIDE    = 3'd5
    } t_cfg_idx;

    typedef logic [SIG_BYTES-1:0][7:0] t_sig;

    // Configuration as seen by the datapath
    typedef struct packed {
        t_sig        sig;
        logic [5:0]  length;
        logic [15:0] stride;
    } t_cfg;

endpackage

/* rtl/wss_cfg_regs.sv */
// Configuration register file of the wildcard signature scanner.
module wss_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    output wss_pkg::t_cfg     o_cfg
);
    import wss_pkg::*;

    logic [3:0][63:0] r_pat;
    logic [5:0]       r_length;
    logic [15:0]      r_stride;

    // Writes are always taken
    assign o_cfg_ready = 1'b1;

    // Register writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat    <= '0;
            r_length <= 6'd1;
            r_stride <= 16'd1;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PAT_0_7:   r_pat[0] <= i_cfg_data;
                CFG_PAT_8_15:  r_pat[1] <= i_cfg_data;
                CFG_PAT_16_23: r_pat[2] <= i_cfg_data;
                CFG_PAT_24_31: r_pat[3] <= i_cfg_data;
                CFG_LENGTH:    r_length <= i_cfg_data[5:0];
                CFG_STRIDE:    r_stride <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.sig    = t_sig'(r_pat);
    assign o_cfg.length = r_length;
    assign o_cfg.stride = r_stride;

endmodule

/* rtl/wss_match.sv */
// Parallel wildcard compare of the byte window against the signature.
module wss_match #(
    parameter int MAX_PATTERN = 32
) (
    input  wss_pkg::t_cfg                    i_cfg,
    input  logic [MAX_PATTERN-1:0][7:0]      i_window,
    input  logic [MAX_PATTERN-1:0]           i_aligned,
    input  logic [31:0]                      i_cur_index,
    output logic                             o_hit,
    output logic [31:0]                      o_offset
);
    import wss_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int KW    = (LEN_W > 6) ? LEN_W : 6;
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [KW-1:0]          len_raw;
    logic [KW-1:0]          len_eff;
    logic [KW-1:0]          len_m1;
    logic [MAX_PATTERN-1:0] byte_ok;

    // Effective length: zero reads as one, saturate at the window depth
    always_comb begin
        len_raw = KW'(i_cfg.length);
        if (len_raw == '0) begin
            len_eff = KW'(1);
        end else if (len_raw > KW'(MAX_PATTERN)) begin
            len_eff = KW'(MAX_PATTERN);
        end else begin
            len_eff = len_raw;
        end
        len_m1 = len_eff - KW'(1);
    end

    // Window entry j (newest at 0) faces signature byte len-1-j
    always_comb begin
        logic [KW-1:0] k;
        logic [7:0]    s;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            k = len_m1 - KW'(j);
            s = (k < KW'(SIG_BYTES)) ? i_cfg.sig[k[4:0]] : WILDCARD;
            byte_ok[j] = (KW'(j) >= len_eff) || (s == WILDCARD) || (s == i_window[j]);
        end
    end

    // Candidate start must be aligned and fully inside the stream
    assign o_hit    = (i_cur_index >= 32'(len_m1)) && i_aligned[len_m1[IDX_W-1:0]]
                      && (&byte_ok);
    assign o_offset = i_cur_index - 32'(len_m1);

endmodule

/* rtl/wildcard_signature_scan.sv */
// Top level of the wildcard signature scanner: input stage, stream state, result register.
//
//  channel  direction  handshake                  payload
//  in       to block   i_in_valid / o_in_ready    i_data_byte, i_last_byte
//  out      from block o_out_valid / i_out_ready  o_found, o_match_offset
//  cfg      to block   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per cycle unless results stall; each result is registered.
// The input register feeds one pass of the parallel window compare into the result register.
// A stalled result holds the input stage; with both stages full o_in_ready drops.
// Synchronous active-low reset clears stream state and loads register defaults.
// No clearing pass: the block takes items from the first cycle after reset.
module wildcard_signature_scan #(
    parameter int MAX_PATTERN = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_found,
    output logic [31:0] o_match_offset,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import wss_pkg::*;

    t_cfg cfg;

    // Input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Stream state
    logic [MAX_PATTERN-1:0][7:0] r_window, n_window;
    logic [MAX_PATTERN-1:0]      r_aligned, n_aligned;
    logic [15:0]                 r_phase, n_phase;
    logic [31:0]                 r_index, n_index;
    logic                        r_matched, n_matched;

    // Result register
    logic        r_out_valid;
    logic        r_found;
    logic [31:0] r_offset;

    logic        advance;
    logic        hit;
    logic [31:0] hit_offset;
    logic        give_result;

    wss_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Stage moves when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // Window and alignment marks with the staged byte shifted in
    logic [MAX_PATTERN-1:0][7:0] w_window;
    logic [MAX_PATTERN-1:0]      w_aligned;
    always_comb begin
        w_window[0]  = r_in_byte;
        w_aligned[0] = (r_phase == 16'd0);
        for (int j = 1; j < MAX_PATTERN; j++) begin
            w_window[j]  = r_window[j-1];
            w_aligned[j] = r_aligned[j-1];
        end
    end

    wss_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .i_cfg       (cfg),
        .i_window    (w_window),
        .i_aligned   (w_aligned),
        .i_cur_index (r_index),
        .o_hit       (hit),
        .o_offset    (hit_offset)
    );

    logic found_now;
    assign found_now   = hit && !r_matched;
    assign give_result = found_now || (r_in_last && !r_matched);

    // Next stream state; the last byte clears the stream
    always_comb begin
        n_window  = r_window;
        n_aligned = r_aligned;
        n_phase   = r_phase;
        n_index   = r_index;
        n_matched = r_matched;
        if (advance) begin
            n_window = w_window;
            if (r_in_last) begin
                n_aligned = '0;
                n_phase   = 16'd0;
                n_index   = 32'd0;
                n_matched = 1'b0;
            end else begin
                n_aligned = w_aligned;
                n_phase   = (({1'b0, r_phase} + 17'd1) >= {1'b0, cfg.stride})
                            ? 16'd0 : r_phase + 16'd1;
                n_index   = (r_index == 32'hFFFF_FFFF) ? r_index : r_index + 32'd1;
                n_matched = r_matched || found_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aligned <= '0;
            r_phase   <= 16'd0;
            r_index   <= 32'd0;
            r_matched <= 1'b0;
        end else begin
            r_aligned <= n_aligned;
            r_phase   <= n_phase;
            r_index   <= n_index;
            r_matched <= n_matched;
        end
    end

    // Window bytes are only read once written in the current stream
    always_ff @(posedge i_clk) begin
        r_window <= n_window;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= give_result;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && give_result) begin
            r_found  <= found_now;
            r_offset <= found_now ? hit_offset : 32'd0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_match_offset = r_offset;

`ifndef NO_ASSERTIONS
    // A not-found result carries a zero offset
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_offset == 32'd0))
        else $error("not-found result with nonzero offset");

    // Stream state is clear after a last byte passes the stage
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (!r_matched && r_index == 32'd0 && r_phase == 16'd0))
        else $error("stream state not cleared after last byte");

    // An empty result register never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with free result register");

    // No second match result within one stream
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_matched) |-> !found_now)
        else $error("second match in one stream");
`endif

endmodule

/* bench/scan_tracker_pkg.sv */
// Expected-result tracking for the wildcard signature scanner testbench.
`timescale 1ns / 1ps

package scan_tracker_pkg;
    import wss_pkg::*;

    // Mismatch lines printed before going quiet
    localparam int SHOW_LIMIT = 20;

    typedef struct packed {
        logic        found;
        logic [31:0] offset;
    } t_scan_report;

    class t_match_tracker;
        // Register mirror
        logic [63:0] sig_word [4];
        logic [5:0]  sig_len;
        logic [15:0] stride_cfg;

        // Stream state, newest byte at entry 0
        logic [7:0]  window [SIG_BYTES];
        bit          aligned [SIG_BYTES];
        logic [15:0] stride_pos;
        logic [31:0] byte_count;
        bit          matched;

        t_scan_report reports [$];
        int mismatches;
        int hits;
        int misses;

        function new();
            foreach (sig_word[w]) sig_word[w] = '0;
            sig_len    = 6'd1;
            stride_cfg = 16'd1;
            mismatches = 0;
            hits       = 0;
            misses     = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            foreach (window[i]) begin
                window[i]  = '0;
                aligned[i] = 1'b0;
            end
            stride_pos = '0;
            byte_count = '0;
            matched    = 1'b0;
        endfunction

        function void write_register(t_cfg_idx idx, logic [63:0] value);
            case (idx)
                CFG_PAT_0_7:   sig_word[0] = value;
                CFG_PAT_8_15:  sig_word[1] = value;
                CFG_PAT_16_23: sig_word[2] = value;
                CFG_PAT_24_31: sig_word[3] = value;
                CFG_LENGTH:    sig_len = value[5:0];
                CFG_STRIDE:    stride_cfg = value[15:0];
                default: ;
            endcase
        endfunction

        function int pending_count();
            return reports.size();
        endfunction

        // Advance the stream by one accepted byte and queue any report it causes
        function void take_byte(logic [7:0] value, logic is_last);
            int unsigned  span;
            logic [31:0]  start_idx;
            logic [7:0]   sig_b;
            bit           hit;
            t_scan_report rep;

            span = (sig_len == 0) ? 1 : ((sig_len > SIG_BYTES) ? SIG_BYTES : sig_len);
            start_idx = byte_count;

            for (int i = SIG_BYTES - 1; i > 0; i--) begin
                window[i]  = window[i-1];
                aligned[i] = aligned[i-1];
            end
            window[0]  = value;
            aligned[0] = (stride_pos == 0);

            // stride of zero behaves like one
            if ({16'd0, stride_pos} + 32'd1 >= {16'd0, stride_cfg})
                stride_pos = '0;
            else
                stride_pos = stride_pos + 16'd1;
            if (byte_count != '1)
                byte_count = byte_count + 32'd1;

            // Candidate start is the oldest byte of the window span
            if (!matched && start_idx >= span - 1 && aligned[span-1]) begin
                hit = 1'b1;
                for (int i = 0; i < span; i++) begin
                    sig_b = sig_word[i/8][(i%8)*8 +: 8];
                    if (sig_b != WILDCARD && sig_b != window[span-1-i])
                        hit = 1'b0;
                end
                if (hit) begin
                    matched    = 1'b1;
                    rep.found  = 1'b1;
                    rep.offset = start_idx - (span - 1);
                    reports.push_back(rep);
                end
            end

            // End of stream: report a miss unless something matched, then start over
            if (is_last) begin
                if (!matched) begin
                    rep.found  = 1'b0;
                    rep.offset = '0;
                    reports.push_back(rep);
                end
                clear_stream();
            end
        endfunction

        function void check_report(logic found, logic [31:0] offset);
            t_scan_report want;

            if (reports.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("%0t: unexpected result found=%0b offset=%0d, none pending",
                             $time, found, offset);
                return;
            end
            want = reports.pop_front();
            if (want.found !== found) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("%0t: found mismatch, expected %0b actual %0b",
                             $time, want.found, found);
            end
            if (want.offset !== offset) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("%0t: match_offset mismatch, expected %0d actual %0d",
                             $time, want.offset, offset);
            end
            if (want.found)
                hits++;
            else
                misses++;
        endfunction
    endclass

endpackage

/* bench/tb_wildcard_signature_scan.sv */
// Top-level testbench of the wildcard signature scanner.
`timescale 1ns / 1ps

module tb_wildcard_signature_scan;
    import wss_pkg::*;
    import scan_tracker_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BYTES  = 135;
    localparam int PHASE_COUNT  = 9;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_found;
    logic [31:0] o_match_offset;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    t_match_tracker tracker;

    // Stimulus-side copy of the signature, used to plant matches
    logic [7:0]  sig_mem [SIG_BYTES];
    int unsigned eff_len = 1;
    int unsigned eff_stride = 1;

    int send_gap_pct = 0;
    int stall_pct = 0;
    int cycles = 0;
    int bytes_sent = 0;
    int settings = 0;

    wildcard_signature_scan u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_match_offset (o_match_offset),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side stalls at random
    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= stall_pct);
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_report(o_found, o_match_offset);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, tracker.pending_count());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one byte, hold it until accepted; returns at a falling edge
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_data_byte = value;
        i_last_byte = is_last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.take_byte(value, is_last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [63:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.write_register(idx, value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Stop sending until every pending result is out, then let the pipe settle
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (tracker.pending_count() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [63:0] packed_word(input int w);
        logic [63:0] word;
        for (int b = 0; b < 8; b++)
            word[b*8 +: 8] = sig_mem[w*8 + b];
        return word;
    endfunction

    task automatic write_scan_config(input int len_field, input int stride_field);
        cfg_write(CFG_PAT_0_7,   packed_word(0));
        cfg_write(CFG_PAT_8_15,  packed_word(1));
        cfg_write(CFG_PAT_16_23, packed_word(2));
        cfg_write(CFG_PAT_24_31, packed_word(3));
        cfg_write(CFG_LENGTH,    64'(len_field));
        cfg_write(CFG_STRIDE,    64'(stride_field));
        eff_len = (len_field == 0) ? 1 : ((len_field > SIG_BYTES) ? SIG_BYTES : len_field);
        eff_stride = (stride_field == 0) ? 1 : stride_field;
        settings++;
    endtask

    task automatic fill_signature(input int wild_pct);
        int r;
        for (int i = 0; i < SIG_BYTES; i++) begin
            r = $urandom_range(99);
            if (r < wild_pct)
                sig_mem[i] = WILDCARD;
            else if (r < wild_pct + 8)
                sig_mem[i] = r[0] ? 8'hFF : 8'h00;
            else
                sig_mem[i] = 8'($urandom);
        end
    endtask

    // One stream: filler close to the signature, often with a planted copy
    task automatic send_stream(output int count);
        logic [7:0] stream_mem [64];
        int         n;
        int         at;
        int         r;
        int         j;
        bit         with_last;

        r = $urandom_range(99);
        if (r < 10)
            n = $urandom_range(eff_len, 1);
        else
            n = eff_len + $urandom_range(20);
        for (int i = 0; i < n; i++) begin
            j = $urandom_range(eff_len - 1);
            if ($urandom_range(99) < 35 || sig_mem[j] == WILDCARD)
                stream_mem[i] = 8'($urandom);
            else
                stream_mem[i] = sig_mem[j];
        end

        // plant at an aligned start, at any start, or not at all
        r = $urandom_range(99);
        if (n >= eff_len && r < 80) begin
            if (r < 60)
                at = $urandom_range((n - eff_len) / eff_stride) * eff_stride;
            else
                at = $urandom_range(n - eff_len);
            for (int i = 0; i < eff_len; i++)
                if (sig_mem[i] != WILDCARD)
                    stream_mem[at + i] = sig_mem[i];
            // near miss: one flipped bit
            if ($urandom_range(99) < 25) begin
                j = $urandom_range(eff_len - 1);
                stream_mem[at + j] ^= 8'h01 << $urandom_range(7);
            end
        end

        // a few streams run on into the next one
        with_last = ($urandom_range(99) >= 8);
        for (int i = 0; i < n; i++)
            send_byte(stream_mem[i], with_last && (i == n - 1));
        count = n;
    endtask

    initial begin
        int lf;
        int sf;
        int n;
        int in_phase;

        tracker = new();
        for (int i = 0; i < SIG_BYTES; i++)
            sig_mem[i] = 8'h00;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_gap_pct = 16;
        stall_pct    = 57;

        // Reset settings: one signature byte 0x00, every offset a candidate
        send_byte(8'h00, 1'b0);        // match at offset 0
        send_byte(8'hFF, 1'b1);        // last byte after a match: nothing
        send_byte(8'hFF, 1'b1);        // single-byte stream, no match

        // Three bytes with a wildcard in the middle, even offsets only
        drain_results();
        sig_mem[0] = 8'h12;
        sig_mem[1] = WILDCARD;
        sig_mem[2] = 8'h34;
        write_scan_config(3, 2);
        send_byte(8'h12, 1'b0);        // match completes on the last byte
        send_byte(8'h55, 1'b0);
        send_byte(8'h34, 1'b1);
        send_byte(8'h12, 1'b0);        // stream shorter than the signature
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);        // odd-offset copy skipped, even one found
        send_byte(8'h12, 1'b0);
        send_byte(8'h77, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h34, 1'b1);

        // Length zero acts as one, stride zero as one
        drain_results();
        sig_mem[0] = 8'hFF;
        write_scan_config(0, 0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Random phases: three pacing modes, three settings each
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p / 3)
                0: begin
                    send_gap_pct = 16;
                    stall_pct    = 57;
                end
                1: begin
                    send_gap_pct = 57;
                    stall_pct    = 16;
                end
                default: begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
            endcase
            case (p)
                0: begin lf = 1;  sf = 1; end
                1: begin lf = 32; sf = 65535; end
                2: begin lf = 63; sf = 0; end
                3: begin lf = 0;  sf = 3; end
                4: begin lf = $urandom_range(8, 2);  sf = $urandom_range(8, 1); end
                5: begin lf = $urandom_range(16, 2); sf = 2; end
                6: begin lf = 5;  sf = 1; end
                7: begin lf = 40; sf = $urandom_range(40, 1); end
                default: begin lf = $urandom_range(32, 1); sf = 4; end
            endcase
            fill_signature((p == 1) ? 50 : 20);
            drain_results();
            write_scan_config(lf, sf);
            in_phase = 0;
            while (in_phase < PHASE_BYTES) begin
                send_stream(n);
                in_phase += n;
                if ($urandom_range(99) < 4)
                    drain_results();
            end
        end

        i_in_valid = 1'b0;
        while (tracker.pending_count() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        $display("Scanned %0d bytes under %0d register settings, with both sides idling and not.",
                 bytes_sent, settings + 1);
        $display("Checked %0d match reports and %0d streams that ended without a match.",
                 tracker.hits, tracker.misses);
        if (tracker.mismatches == 0 && tracker.pending_count() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/wss_pkg.sv
rtl/wss_cfg_regs.sv
rtl/wss_match.sv
rtl/wildcard_signature_scan.sv
bench/scan_tracker_pkg.sv
bench/tb_wildcard_signature_scan.sv
